FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/bmq_pkg.sv
// constants, op codes and search types for the multilevel task queue
// no dependencies
`default_nettype none
package bmq_pkg;

   localparam int NUM_LEVELS = 32;
   localparam int NUM_TASKS  = 32;
   localparam int LEVEL_W    = 5;
   localparam int TASK_W     = 5;
   localparam int ADJ_W      = 6;
   localparam int COUNT_W    = 6;
   localparam int OP_W       = 3;
   localparam int CELL_W     = 8;
   localparam int NUM_CELLS  = NUM_LEVELS / CELL_W;
   localparam int CELL_IDX_W = 2;
   localparam int SLOT_W     = 3;

   localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
   localparam logic [OP_W-1:0] OP_PICK    = 3'd1;
   localparam logic [OP_W-1:0] OP_REQUEUE = 3'd2;
   localparam logic [OP_W-1:0] OP_BOOST   = 3'd3;
   localparam logic [OP_W-1:0] OP_WAKE    = 3'd4;

   typedef struct packed {
      logic               found;
      logic [LEVEL_W-1:0] level;
   } search_type;

   // lowest set bit of one cell's slice
   function automatic logic [SLOT_W-1:0] first_set(input logic [CELL_W-1:0] bits);
      logic [SLOT_W-1:0] r;
      r = '0;
      for (int i = CELL_W - 1; i >= 0; i--) begin
         if (bits[i]) r = SLOT_W'(i);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/bmq_cell.sv
// one search cell: covers a slice of the level bitmap, hands result onward
// depends on bmq_pkg
`default_nettype none
module bmq_cell import bmq_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [CELL_IDX_W-1:0] cell_idx,
   input  wire logic [CELL_W-1:0]     level_bits,
   input  wire search_type            prev_search,
   output search_type                 next_search
);

   search_type search_ff, search_in;

   always_comb begin
      search_in = prev_search;
      if (!prev_search.found && (|level_bits)) begin
         search_in.found = 1'b1;
         search_in.level = {cell_idx, first_set(level_bits)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_ff.found <= 1'b0;
      end else begin
         search_ff.found <= search_in.found;
      end
      search_ff.level <= search_in.level;
   end

   assign next_search = search_ff;

endmodule
`default_nettype wire

FILE: hdl/bitmap_multilevel_task_queue.sv
// top level of the multilevel task queue: sequencer, queue tables, search chain
// depends on bmq_pkg, bmq_cell and assert_macros.svh
`default_nettype none
// Multilevel ready queue for 32 tasks over 32 priority levels, level 0 most
// urgent. A command is taken when start is high and busy is low; its single
// result appears on the rsp_ ports for one cycle with rsp_valid high and must
// be captured then, since the receiver cannot stall. Add, requeue, boost and
// wake go through the execute state with the table read-modify-write, then the
// result register. Pick waits in the search state while the lowest nonempty
// level is found by a chain of 4 cells, 8 levels each, that passes its search
// result one cell per cycle; then the level's head is read and the task is
// unlinked, or an empty result is made if the bitmap is empty, then the result
// register. busy is low in the cycle the result shows, so a new command may
// go in alongside it. max_adjust is written through csr_valid/csr_ready
// (always ready) and must only be written while busy is low.
module bitmap_multilevel_task_queue import bmq_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [OP_W-1:0]    req_op,
   input  wire logic [TASK_W-1:0]  req_task_req,
   input  wire logic [LEVEL_W-1:0] req_static_level,
   output logic                    rsp_valid,
   output logic                    rsp_picked_valid,
   output logic [TASK_W-1:0]       rsp_picked_task,
   output logic [LEVEL_W-1:0]      rsp_picked_level,
   output logic [LEVEL_W-1:0]      rsp_task_level,
   output logic [COUNT_W-1:0]      rsp_ready_count,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [4:0]         csr_max_adjust
);
`include "assert_macros.svh"

   // sequencer states
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SEARCH    = 3'd1;
   localparam logic [2:0] ST_PICK_HEAD = 3'd2;
   localparam logic [2:0] ST_PICK_POP  = 3'd3;
   localparam logic [2:0] ST_EXEC      = 3'd4;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(NUM_LEVELS - 1);
   localparam logic signed [ADJ_W:0] SUM_MAX = (ADJ_W + 1)'(NUM_LEVELS - 1);

   logic [2:0]            state_ff, state_in;
   logic [CELL_IDX_W-1:0] cnt_ff, cnt_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [TASK_W-1:0]     task_ff, task_in;
   logic [LEVEL_W-1:0]    sl_ff, sl_in;
   logic [LEVEL_W-1:0]    lv_ff, lv_in;
   logic [TASK_W-1:0]     head_task_ff, head_task_in;
   logic [NUM_LEVELS-1:0] bitmap_ff, bitmap_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [4:0]            max_adjust_ff, max_adjust_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_pv_ff, rsp_pv_in;
   logic [TASK_W-1:0]     rsp_pt_ff, rsp_pt_in;
   logic [LEVEL_W-1:0]    rsp_pl_ff, rsp_pl_in;
   logic [LEVEL_W-1:0]    rsp_tl_ff, rsp_tl_in;

   // per-level and per-task tables
   logic [TASK_W-1:0]        queue_head [NUM_LEVELS];
   logic [TASK_W-1:0]        queue_tail [NUM_LEVELS];
   logic [TASK_W-1:0]        next_link [NUM_TASKS];
   logic [LEVEL_W-1:0]       base_level [NUM_TASKS];
   logic signed [ADJ_W-1:0]  level_adjust [NUM_TASKS];
   logic [LEVEL_W-1:0]       effective_level [NUM_TASKS];
   logic [NUM_TASKS-1:0]     task_queued_ff;

   // search chain
   search_type chain_w [NUM_CELLS + 1];
   assign chain_w[0] = '0;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      bmq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_idx    (CELL_IDX_W'(g)),
         .level_bits  (bitmap_ff[g*CELL_W +: CELL_W]),
         .prev_search (chain_w[g]),
         .next_search (chain_w[g+1])
      );
   end

   search_type found_w;
   assign found_w = chain_w[NUM_CELLS];

   // table read ports, one address each per cycle
   logic [TASK_W-1:0]       task_addr;
   logic [LEVEL_W-1:0]      tail_addr;
   logic signed [ADJ_W-1:0] cur_adj;
   logic [LEVEL_W-1:0]      cur_base, cur_eff, tail_rd;
   logic                    cur_q;

   // execute path
   logic signed [ADJ_W-1:0] mx_s, new_adj;
   logic signed [ADJ_W:0]   lv_sum;
   logic [LEVEL_W-1:0]      new_base, new_eff, sl_sat;
   logic                    is_enq_op, do_update, do_enq, enq_bit, pop_last;

   // table write controls
   logic                    we_head, we_tail, we_link, we_task, we_q, q_val;
   logic [LEVEL_W-1:0]      head_waddr;
   logic [TASK_W-1:0]       head_wdata, link_waddr, q_addr;

   assign task_addr = (state_ff == ST_PICK_POP) ? head_task_ff : task_ff;
   assign cur_adj   = level_adjust[task_addr];
   assign cur_base  = base_level[task_addr];
   assign cur_eff   = effective_level[task_addr];
   assign cur_q     = task_queued_ff[task_addr];
   assign tail_addr = (state_ff == ST_PICK_POP) ? lv_ff : new_eff;
   assign tail_rd   = queue_tail[tail_addr];

   always_comb begin
      mx_s     = signed'({1'b0, max_adjust_ff});
      sl_sat   = (sl_ff > LEVEL_MAX) ? LEVEL_MAX : sl_ff;
      new_base = cur_base;
      new_adj  = cur_adj;
      case (op_ff)
         OP_ADD: begin
            new_base = sl_sat;
            new_adj  = '0;
         end
         OP_REQUEUE: if (cur_adj < mx_s) new_adj = cur_adj + 6'sd1;
         OP_BOOST:   if (cur_adj > -mx_s) new_adj = cur_adj - 6'sd1;
         default: ;
      endcase
      lv_sum  = signed'({2'b00, new_base}) + (ADJ_W + 1)'(new_adj);
      new_eff = cur_eff;
      if (op_ff == OP_ADD) begin
         new_eff = sl_sat;
      end else if ((op_ff == OP_REQUEUE || op_ff == OP_BOOST) &&
                   lv_sum >= 0 && lv_sum <= SUM_MAX) begin
         new_eff = lv_sum[LEVEL_W-1:0];
      end
      is_enq_op = (op_ff == OP_ADD) || (op_ff == OP_REQUEUE) || (op_ff == OP_WAKE);
      do_enq    = (state_ff == ST_EXEC) && is_enq_op && !cur_q;
      do_update = do_enq || ((state_ff == ST_EXEC) && (op_ff == OP_BOOST));
      enq_bit   = bitmap_ff[new_eff];
      pop_last  = (head_task_ff == tail_rd);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      task_in       = task_ff;
      sl_in         = sl_ff;
      lv_in         = lv_ff;
      head_task_in  = head_task_ff;
      bitmap_in     = bitmap_ff;
      count_in      = count_ff;
      max_adjust_in = max_adjust_ff;
      rsp_valid_in  = 1'b0;
      rsp_pv_in     = 1'b0;
      rsp_pt_in     = '0;
      rsp_pl_in     = '0;
      rsp_tl_in     = '0;
      we_head       = 1'b0;
      we_tail       = 1'b0;
      we_link       = 1'b0;
      we_task       = do_update;
      we_q          = 1'b0;
      q_val         = 1'b0;
      q_addr        = task_ff;
      head_waddr    = new_eff;
      head_wdata    = task_ff;
      link_waddr    = tail_rd;

      if (csr_valid) max_adjust_in = csr_max_adjust;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_op;
               task_in  = req_task_req;
               sl_in    = req_static_level;
               cnt_in   = '0;
               state_in = (req_op == OP_PICK) ? ST_SEARCH : ST_EXEC;
            end
         end
         ST_SEARCH: begin
            // wait for the result to ripple through every cell
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CELL_IDX_W'(NUM_CELLS - 1)) state_in = ST_PICK_HEAD;
         end
         ST_PICK_HEAD: begin
            if (found_w.found) begin
               lv_in        = found_w.level;
               head_task_in = queue_head[found_w.level];
               state_in     = ST_PICK_POP;
            end else begin
               // nothing queued
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_PICK_POP: begin
            if (pop_last) begin
               bitmap_in[lv_ff] = 1'b0;
            end else begin
               we_head    = 1'b1;
               head_waddr = lv_ff;
               head_wdata = next_link[head_task_ff];
            end
            we_q   = 1'b1;
            q_addr = head_task_ff;
            if (count_ff != '0) count_in = count_ff - 1'b1;
            rsp_valid_in = 1'b1;
            rsp_pv_in    = 1'b1;
            rsp_pt_in    = head_task_ff;
            rsp_pl_in    = lv_ff;
            rsp_tl_in    = cur_eff;
            state_in     = ST_IDLE;
         end
         ST_EXEC: begin
            if (do_enq) begin
               we_head             = !enq_bit;
               we_link             = enq_bit;
               we_tail             = 1'b1;
               we_q                = 1'b1;
               q_val               = 1'b1;
               bitmap_in[new_eff]  = 1'b1;
               count_in            = count_ff + 1'b1;
            end
            rsp_valid_in = 1'b1;
            if (op_ff <= OP_WAKE) rsp_tl_in = do_update ? new_eff : cur_eff;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         bitmap_ff      <= '0;
         count_ff       <= '0;
         max_adjust_ff  <= 5'd4;
         task_queued_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_pv_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         bitmap_ff     <= bitmap_in;
         count_ff      <= count_in;
         max_adjust_ff <= max_adjust_in;
         if (we_q) task_queued_ff[q_addr] <= q_val;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_pv_ff     <= rsp_pv_in;
      end
      op_ff        <= op_in;
      task_ff      <= task_in;
      sl_ff        <= sl_in;
      lv_ff        <= lv_in;
      head_task_ff <= head_task_in;
      rsp_pt_ff    <= rsp_pt_in;
      rsp_pl_ff    <= rsp_pl_in;
      rsp_tl_ff    <= rsp_tl_in;
   end

   // table writes, no reset: entries are defined once a task is added
   always_ff @(posedge clock) begin
      if (we_head) queue_head[head_waddr] <= head_wdata;
      if (we_tail) queue_tail[new_eff] <= task_ff;
      if (we_link) next_link[link_waddr] <= task_ff;
      if (we_task) begin
         base_level[task_ff]      <= new_base;
         level_adjust[task_ff]    <= new_adj;
         effective_level[task_ff] <= new_eff;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_picked_valid = rsp_pv_ff;
   assign rsp_picked_task  = rsp_pt_ff;
   assign rsp_picked_level = rsp_pl_ff;
   assign rsp_task_level   = rsp_tl_ff;
   assign rsp_ready_count  = count_ff;

   // a result only shows once the sequencer is back to idle
   `ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // one result per command, never two in a row
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // bitmap and queued count agree on emptiness
   `ASSERT_IMPL(a_count_map, clock, reset, 1'b1, ((count_ff == '0) == (bitmap_ff == '0)))
   // never more queued than tasks exist
   `ASSERT_IMPL(a_count_max, clock, reset, 1'b1, (count_ff <= COUNT_W'(NUM_TASKS)))
   // a picked flag only rides on a result strobe
   `ASSERT_IMPL(a_pick_strobe, clock, reset, rsp_picked_valid, rsp_valid)

endmodule
`default_nettype wire

FILE: verif/bitmap_multilevel_task_queue_test.sv
// self-checking testbench for the multilevel task queue
// depends on bmq_pkg and the bitmap_multilevel_task_queue rtl
`default_nettype none

// expected response fields of one command
typedef struct {
   logic       picked_valid;
   logic [4:0] picked_task;
   logic [4:0] picked_level;
   logic [4:0] task_level;
   logic [5:0] ready_count;
} sched_resp_type;

class sched_scoreboard;
   // mirror of the scheduler tables
   logic [31:0] nonempty;
   logic [4:0]  head_of[32];
   logic [4:0]  tail_of[32];
   logic [4:0]  link_of[32];
   logic [4:0]  base_of[32];
   int          adj_of[32];
   logic [4:0]  eff_of[32];
   bit          queued[32];
   bit          added[32];
   int          total;
   int          max_adj;
   int          errors;
   sched_resp_type pending[$];

   function new();
      nonempty = '0;
      total    = 0;
      max_adj  = 4;
      errors   = 0;
      foreach (added[i]) begin
         added[i]  = 0;
         queued[i] = 0;
      end
   endfunction

   // effective level moves only when base plus adjustment stays in range
   function void settle_level(int t);
      int lv;
      lv = int'(base_of[t]) + adj_of[t];
      if (lv >= 0 && lv <= bmq_pkg::NUM_LEVELS - 1) eff_of[t] = lv[4:0];
   endfunction

   function void push_task(int t);
      logic [4:0] lv;
      lv = eff_of[t];
      link_of[t] = '0;
      if (!nonempty[lv]) head_of[lv] = t[4:0];
      else link_of[tail_of[lv]] = t[4:0];
      tail_of[lv]  = t[4:0];
      nonempty[lv] = 1'b1;
      queued[t]    = 1;
      total++;
   endfunction

   // called at the transfer edge of each command
   function void note_command(logic [2:0] op, logic [4:0] t, logic [4:0] sl);
      sched_resp_type r;
      int          lv;
      logic [4:0]  h;
      r = '{1'b0, 5'd0, 5'd0, 5'd0, 6'd0};
      if (op == bmq_pkg::OP_PICK) begin
         lv = -1;
         for (int i = 31; i >= 0; i--) if (nonempty[i]) lv = i;
         if (lv >= 0) begin
            h = head_of[lv];
            if (h == tail_of[lv]) nonempty[lv] = 1'b0;
            else head_of[lv] = link_of[h];
            link_of[h] = '0;
            queued[h]  = 0;
            if (total > 0) total--;
            r.picked_valid = 1'b1;
            r.picked_task  = h;
            r.picked_level = lv[4:0];
            r.task_level   = eff_of[h];
         end
      end else if (op <= bmq_pkg::OP_WAKE) begin
         if (op == bmq_pkg::OP_BOOST) begin
            if (adj_of[t] > -max_adj) adj_of[t]--;
            settle_level(t);
         end else if (!queued[t]) begin
            if (op == bmq_pkg::OP_ADD) begin
               base_of[t] = sl;
               adj_of[t]  = 0;
               eff_of[t]  = sl;
               added[t]   = 1;
            end else if (op == bmq_pkg::OP_REQUEUE) begin
               if (adj_of[t] < max_adj) adj_of[t]++;
               settle_level(t);
            end
            push_task(t);
         end
         r.task_level = eff_of[t];
      end
      r.ready_count = total[5:0];
      pending.push_back(r);
   endfunction

   function void check_result(sched_resp_type got);
      sched_resp_type w;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response, none pending", $time);
         errors++;
         return;
      end
      w = pending.pop_front();
      if (got.picked_valid !== w.picked_valid) begin
         $display("%0t: picked_valid exp %0d got %0d", $time, w.picked_valid, got.picked_valid);
         errors++;
      end
      if (got.picked_task !== w.picked_task) begin
         $display("%0t: picked_task exp %0d got %0d", $time, w.picked_task, got.picked_task);
         errors++;
      end
      if (got.picked_level !== w.picked_level) begin
         $display("%0t: picked_level exp %0d got %0d", $time, w.picked_level,
                  got.picked_level);
         errors++;
      end
      if (got.task_level !== w.task_level) begin
         $display("%0t: task_level exp %0d got %0d", $time, w.task_level, got.task_level);
         errors++;
      end
      if (got.ready_count !== w.ready_count) begin
         $display("%0t: ready_count exp %0d got %0d", $time, w.ready_count, got.ready_count);
         errors++;
      end
   endfunction
endclass

module bitmap_multilevel_task_queue_test;
   import bmq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [OP_W-1:0]    req_op = '0;
   logic [TASK_W-1:0]  req_task_req = '0;
   logic [LEVEL_W-1:0] req_static_level = '0;
   logic               rsp_valid;
   logic               rsp_picked_valid;
   logic [TASK_W-1:0]  rsp_picked_task;
   logic [LEVEL_W-1:0] rsp_picked_level;
   logic [LEVEL_W-1:0] rsp_task_level;
   logic [COUNT_W-1:0] rsp_ready_count;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [4:0]         csr_max_adjust = '0;

   sched_scoreboard sb = new();
   int unsigned     cycles = 0;

   bitmap_multilevel_task_queue dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_task_req(req_task_req),
      .req_static_level(req_static_level),
      .rsp_valid(rsp_valid), .rsp_picked_valid(rsp_picked_valid),
      .rsp_picked_task(rsp_picked_task), .rsp_picked_level(rsp_picked_level),
      .rsp_task_level(rsp_task_level), .rsp_ready_count(rsp_ready_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_max_adjust(csr_max_adjust)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response monitor: the strobe lasts one cycle, no back-pressure possible
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result('{rsp_picked_valid, rsp_picked_task, rsp_picked_level,
                           rsp_task_level, rsp_ready_count});
   end

   // watchdog, far above the slowest legal run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 300000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // one command transfer; start stays high so bursts run back to back
   task automatic issue(logic [2:0] op, logic [4:0] t, logic [4:0] sl);
      start            <= 1'b1;
      req_op           <= op;
      req_task_req     <= t;
      req_static_level <= sl;
      do @(posedge clock); while (busy);
      sb.note_command(op, t, sl);
   endtask

   task automatic pause(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // csr writes only once every response is back
   task automatic set_max_adjust(logic [4:0] v);
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_max_adjust <= v;
      do @(posedge clock); while (!csr_ready);
      sb.max_adj = int'(v);
      csr_valid <= 1'b0;
   endtask

   // random command; requeue, boost and wake only name tasks already added
   task automatic random_command();
      int          w;
      logic [2:0]  op;
      logic [4:0]  t;
      w = $urandom_range(99);
      t = 5'($urandom_range(31));
      if (w < 26) op = OP_ADD;
      else if (w < 52) op = OP_PICK;
      else if (w < 72) op = OP_REQUEUE;
      else if (w < 86) op = OP_BOOST;
      else if (w < 96) op = OP_WAKE;
      else op = 3'($urandom_range(7, 5));
      if ((op == OP_REQUEUE || op == OP_BOOST || op == OP_WAKE) && !sb.added[t])
         op = OP_ADD;
      issue(op, t, 5'($urandom_range(31)));
   endtask

   // bursts of random length, gaps of random length, some phases gapless
   task automatic random_phase(int n);
      int  done;
      int  burst;
      bit  tight;
      done  = 0;
      tight = ($urandom_range(3) == 0);
      while (done < n) begin
         burst = $urandom_range(12, 1);
         for (int i = 0; i < burst && done < n; i++) begin
            random_command();
            done++;
         end
         if (!tight) pause($urandom_range(6, 1));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pick, level extremes, duplicate add, adjustment limits
      issue(OP_PICK, 5'd0, 5'd0);
      issue(OP_ADD, 5'd0, 5'd0);
      issue(OP_ADD, 5'd31, 5'd31);
      issue(OP_ADD, 5'd31, 5'd7);
      issue(OP_WAKE, 5'd0, 5'd0);
      issue(OP_REQUEUE, 5'd31, 5'd0);
      for (int i = 0; i < 6; i++) issue(OP_BOOST, 5'd0, 5'd0);
      for (int i = 5; i <= 7; i++) issue(3'(i), 5'd31, 5'd31);
      issue(OP_ADD, 5'd21, 5'd10);
      issue(OP_ADD, 5'd10, 5'd10);
      issue(OP_BOOST, 5'd21, 5'd0);
      for (int i = 0; i < 5; i++) issue(OP_PICK, 5'd0, 5'd0);
      for (int i = 0; i < 6; i++) issue(OP_REQUEUE, 5'd31, 5'd0);
      pause(2);

      set_max_adjust(5'd31);
      random_phase(400);
      set_max_adjust(5'd0);
      random_phase(400);
      set_max_adjust(5'($urandom_range(30, 1)));
      random_phase(400);
      set_max_adjust(5'd4);
      random_phase(400);

      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
